// File: hw/rtl/tmtc_pkg.sv
// Shared types and constants for the three-channel trimmed-mean unit.
// No dependencies; used by the top level, tmtc_lane and tmtc_merge.
`timescale 1ns / 1ps
`default_nettype none

package tmtc_pkg;

  // Width of each mean on the result ports.
  localparam int unsigned OUT_W = 10;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FIN
  } tmtc_state_t;

  // Per-lane command strobes from the sequencer.
  typedef struct packed {
    logic wr;        // store the sample at idx
    logic clr;       // clear the accumulator
    logic scan;      // rank the entry at idx and accumulate
    logic div_load;  // scale the accumulator into the mean register
  } tmtc_lane_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/trimmed_mean_three_channel_unit.sv
// Top level of the three-channel trimmed-mean unit: sequencer, three lanes
// and the merge stage. Depends on tmtc_pkg, tmtc_lane and tmtc_merge.
// A frame that does not close a window leaves busy low.
// The frame that closes a window holds busy through the rank scan over the
// window, one entry per cycle, the scaling of the trimmed sum by 1/KEEP and
// the hand-off; out_valid is high in the first cycle after busy.
// No frame is accepted while busy.
// Reset (synchronous, rst_n low) empties the window and drops busy/out_valid.
`timescale 1ns / 1ps
`default_nettype none

module trimmed_mean_three_channel_unit #(
  parameter int unsigned WINDOW      = 10,
  parameter int unsigned KEEP        = 4,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [SAMPLE_BITS-1:0]     in_left_sample,
  input  wire logic [SAMPLE_BITS-1:0]     in_center_sample,
  input  wire logic [SAMPLE_BITS-1:0]     in_right_sample,
  output logic                            out_valid,
  output logic [tmtc_pkg::OUT_W-1:0]      out_left_mean,
  output logic [tmtc_pkg::OUT_W-1:0]      out_center_mean,
  output logic [tmtc_pkg::OUT_W-1:0]      out_right_mean
);

  localparam int unsigned IW = $clog2(WINDOW);

  tmtc_pkg::tmtc_state_t     state_r, state_nxt;
  logic [IW-1:0]             fill_r, fill_nxt;   // frames in current window
  logic [IW-1:0]             scan_r, scan_nxt;   // entry being ranked
  tmtc_pkg::tmtc_lane_ctrl_t ctrl;
  logic [IW-1:0]             lane_idx;
  logic                      xfer;
  logic                      merge_go;

  logic [SAMPLE_BITS-1:0]    left_mean, center_mean, right_mean;

  // A frame transfers when start meets an idle sequencer.
  assign xfer = start && (state_r == tmtc_pkg::ST_IDLE);
  assign busy = (state_r != tmtc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmtc_pkg::ST_IDLE;
      fill_r  <= '0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      scan_r  <= scan_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    scan_nxt  = scan_r;
    ctrl      = '0;
    lane_idx  = fill_r;
    merge_go  = 1'b0;

    case (state_r)
      tmtc_pkg::ST_IDLE: begin
        lane_idx = fill_r;
        if (xfer) begin
          ctrl.wr = 1'b1;
          if (fill_r == IW'(WINDOW - 1)) begin
            // Window closes: rank it next.
            ctrl.clr  = 1'b1;
            fill_nxt  = '0;
            scan_nxt  = '0;
            state_nxt = tmtc_pkg::ST_SCAN;
          end else begin
            fill_nxt = fill_r + IW'(1);
          end
        end
      end
      tmtc_pkg::ST_SCAN: begin
        lane_idx  = scan_r;
        ctrl.scan = 1'b1;
        if (scan_r == IW'(WINDOW - 1)) begin
          state_nxt = tmtc_pkg::ST_DIV;
        end else begin
          scan_nxt = scan_r + IW'(1);
        end
      end
      tmtc_pkg::ST_DIV: begin
        // Trimmed sums are complete; scale them into the means.
        ctrl.div_load = 1'b1;
        state_nxt     = tmtc_pkg::ST_FIN;
      end
      tmtc_pkg::ST_FIN: begin
        // Quotients are settled; hand them to the merge stage.
        merge_go  = 1'b1;
        state_nxt = tmtc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tmtc_pkg::ST_IDLE;
      end
    endcase
  end

  tmtc_lane #(
    .WINDOW      (WINDOW),
    .KEEP        (KEEP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk    (clk),
    .ctrl   (ctrl),
    .idx    (lane_idx),
    .sample (in_left_sample),
    .mean   (left_mean)
  );

  tmtc_lane #(
    .WINDOW      (WINDOW),
    .KEEP        (KEEP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_center (
    .clk    (clk),
    .ctrl   (ctrl),
    .idx    (lane_idx),
    .sample (in_center_sample),
    .mean   (center_mean)
  );

  tmtc_lane #(
    .WINDOW      (WINDOW),
    .KEEP        (KEEP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk    (clk),
    .ctrl   (ctrl),
    .idx    (lane_idx),
    .sample (in_right_sample),
    .mean   (right_mean)
  );

  tmtc_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (merge_go),
    .left_mean   (left_mean),
    .center_mean (center_mean),
    .right_mean  (right_mean),
    .valid       (out_valid),
    .left_out    (out_left_mean),
    .center_out  (out_center_mean),
    .right_out   (out_right_mean)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tmtc_lane.sv
// One channel lane: sample window, rank scan with trimmed sum, and a
// reciprocal multiply that divides the sum by KEEP. Depends on tmtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmtc_lane #(
  parameter int unsigned WINDOW      = 10,
  parameter int unsigned KEEP        = 4,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                         clk,
  input  wire tmtc_pkg::tmtc_lane_ctrl_t    ctrl,
  input  wire logic [$clog2(WINDOW)-1:0]    idx,
  input  wire logic [SAMPLE_BITS-1:0]       sample,
  output logic      [SAMPLE_BITS-1:0]       mean
);

  localparam int unsigned IW    = $clog2(WINDOW);
  localparam int unsigned KW    = ($clog2(KEEP) < 1) ? 1 : $clog2(KEEP);
  localparam int unsigned SUM_W = SAMPLE_BITS + KW;
  localparam int          TRIM  = (int'(WINDOW) - int'(KEEP)) / 2;
  // floor(sum / KEEP) == (sum * RCP) >> SH for every sum below 2**SUM_W.
  localparam int unsigned SH    = SUM_W + KW;
  localparam int unsigned RW    = SUM_W + 1;
  localparam int unsigned PW    = SUM_W + RW;
  localparam longint unsigned RCP_VAL =
    ((64'd1 << SH) + 64'(KEEP) - 64'd1) / 64'(KEEP);
  localparam logic [RW-1:0] RCP = RW'(RCP_VAL);

  logic [SAMPLE_BITS-1:0] win_r [WINDOW];
  logic [SUM_W-1:0]       acc_r, acc_nxt;
  logic [SAMPLE_BITS-1:0] quo_r, quo_nxt;

  logic [SAMPLE_BITS-1:0] pick;
  logic [WINDOW-1:0]      below;
  logic [IW-1:0]          rank;
  logic                   keep_it;
  logic [PW-1:0]          prod;

  // Stable rank of the picked entry: earlier index wins a tie.
  always_comb begin
    pick = win_r[idx];
    for (int j = 0; j < int'(WINDOW); j++) begin
      below[j] = (win_r[j] < pick) || ((win_r[j] == pick) && (IW'(j) < idx));
    end
    rank    = IW'($countones(below));
    keep_it = (int'(rank) >= TRIM) && (int'(rank) < TRIM + int'(KEEP));
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (ctrl.scan && keep_it) begin
      acc_nxt = acc_r + SUM_W'(pick);
    end
  end

  // Quotient is registered on div_load; the top bits of the product are always zero.
  always_comb begin
    prod    = PW'(acc_r) * PW'(RCP);
    quo_nxt = quo_r;
    if (ctrl.div_load) begin
      quo_nxt = prod[SH +: SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      win_r[idx] <= sample;
    end
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
  end

  assign mean = quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/tmtc_merge.sv
// Merge stage: gathers the three lane means into the result register and
// raises the one-cycle strobe. Depends on tmtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmtc_merge #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [SAMPLE_BITS-1:0]       left_mean,
  input  wire logic [SAMPLE_BITS-1:0]       center_mean,
  input  wire logic [SAMPLE_BITS-1:0]       right_mean,
  output logic                              valid,
  output logic      [tmtc_pkg::OUT_W-1:0]   left_out,
  output logic      [tmtc_pkg::OUT_W-1:0]   center_out,
  output logic      [tmtc_pkg::OUT_W-1:0]   right_out
);

  localparam int unsigned MW = (SAMPLE_BITS > tmtc_pkg::OUT_W) ? SAMPLE_BITS
                                                               : tmtc_pkg::OUT_W;

  logic                       valid_r;
  logic [tmtc_pkg::OUT_W-1:0] left_r, center_r, right_r;
  logic [MW-1:0]              left_x, center_x, right_x;

  assign left_x   = MW'(left_mean);
  assign center_x = MW'(center_mean);
  assign right_x  = MW'(right_mean);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      left_r   <= left_x[tmtc_pkg::OUT_W-1:0];
      center_r <= center_x[tmtc_pkg::OUT_W-1:0];
      right_r  <= right_x[tmtc_pkg::OUT_W-1:0];
    end
  end

  assign valid      = valid_r;
  assign left_out   = left_r;
  assign center_out = center_r;
  assign right_out  = right_r;

endmodule

`default_nettype wire

// File: hw/rtl/tmtc_checker.sv
// Port-level checks for the trimmed-mean unit, bound to the top level.
// Depends only on the top level's control ports.
`timescale 1ns / 1ps
`default_nettype none

module tmtc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // A result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held longer than one cycle");

  // The strobe comes as the unit goes idle again.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("out_valid not at the end of a busy stretch");

  // busy only rises after a frame transfer.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

  // Busy ends with a result strobe right after.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

endmodule

bind trimmed_mean_three_channel_unit tmtc_checker u_tmtc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire
